/* rtl/five_clique_enumerator_top_assert.svh */
// Assertion macros for the five-clique enumerator RTL.
`ifndef FIVE_CLIQUE_ENUMERATOR_TOP_ASSERT_SVH
`define FIVE_CLIQUE_ENUMERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while rst_n is low
`define FCE_ASSERT_IMP(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while rst_n is low
`define FCE_ASSERT_NXT(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fce_pkg.sv */
// Shared constants, types and bitset helpers for the five-clique enumerator.
package fce_pkg;

    localparam int VERTICES_DEF    = 64;
    localparam int ROW_W           = 64;
    localparam int VTX_W           = 6;
    localparam int CNT_W           = 7;
    localparam int CLIQUE_SIZE     = 5;
    localparam int PAIR_MIN_COMMON = 3;
    localparam int LVL_W           = 3;
    localparam int CAND_DEPTH      = CLIQUE_SIZE - 1;
    localparam int CAND_AW         = $clog2(CAND_DEPTH);

    localparam logic [LVL_W-1:0] LVL_ROOT = LVL_W'(0);
    localparam logic [LVL_W-1:0] LVL_PAIR = LVL_W'(1);
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(CLIQUE_SIZE - 1);

    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(64);

    // Input word modes
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_RESTART = 2'd1;
    localparam logic [1:0] MODE_FETCH   = 2'd2;

    typedef logic [VTX_W-1:0] t_vtx;

    typedef struct packed {
        logic fetch;
        logic restart;
    } t_srch_req;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic                        res_valid;
        logic                        found;
        t_vtx [CLIQUE_SIZE-1:0]      vtx;
    } t_srch_rsp;

    // Bits of vertices below min(count, vertices)
    function automatic logic [ROW_W-1:0] active_mask(input logic [CNT_W-1:0] count,
                                                     input int vertices);
        logic [ROW_W-1:0] m;
        for (int p = 0; p < ROW_W; p++) begin
            m[p] = (p < int'(count)) && (p < vertices);
        end
        return m;
    endfunction

    // Lowest set bit at or above start; ROW_W when there is none
    function automatic logic [CNT_W-1:0] first_set_from(input logic [ROW_W-1:0] x,
                                                        input logic [CNT_W-1:0] start);
        logic [CNT_W-1:0] pos;
        pos = CNT_W'(ROW_W);
        for (int p = ROW_W - 1; p >= 0; p--) begin
            if (x[p] && (p >= int'(start))) begin
                pos = CNT_W'(p);
            end
        end
        return pos;
    endfunction

    // True when x has at least PAIR_MIN_COMMON set bits
    function automatic logic has_min_common(input logic [ROW_W-1:0] x);
        logic [ROW_W-1:0] y;
        y = x;
        for (int k = 0; k < PAIR_MIN_COMMON - 1; k++) begin
            y = y & (y - ROW_W'(1));
        end
        return y != '0;
    endfunction

endpackage

/* rtl/fce_row_store.sv */
// Adjacency row memory: one write port, one registered read port.
module fce_row_store #(
    parameter int VERTICES = fce_pkg::VERTICES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [$clog2(VERTICES)-1:0] i_wr_addr,
    input  logic [fce_pkg::ROW_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [$clog2(VERTICES)-1:0] i_rd_addr,
    output logic [fce_pkg::ROW_W-1:0] o_rd_data
);

    logic [fce_pkg::ROW_W-1:0] r_mem [VERTICES];
    logic [fce_pkg::ROW_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/fce_search.sv */
// Backtracking search sequencer: level candidates, chosen path, row fetches.
`include "five_clique_enumerator_top_assert.svh"

module fce_search #(
    parameter int VERTICES = fce_pkg::VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fce_pkg::t_srch_req          i_req,
    input  logic [fce_pkg::CNT_W-1:0]   i_count,
    output fce_pkg::t_srch_rsp          o_rsp,
    output logic                        o_rd_en,
    output logic [$clog2(VERTICES)-1:0] o_rd_addr,
    input  logic [fce_pkg::ROW_W-1:0]   i_rd_data
);

    localparam int AW = $clog2(VERTICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_EXPAND,
        ST_PRUNE
    } t_state;

    t_state                      r_state;
    logic [fce_pkg::LVL_W-1:0]   r_lvl;
    logic                        r_incl;
    logic                        r_done;
    fce_pkg::t_vtx               r_chosen [fce_pkg::CLIQUE_SIZE];
    logic [fce_pkg::ROW_W-1:0]   r_cand [fce_pkg::CAND_DEPTH];
    logic                        r_res_valid;
    logic                        r_found;
    fce_pkg::t_vtx [fce_pkg::CLIQUE_SIZE-1:0] r_vtx;

    logic [fce_pkg::ROW_W-1:0]   act_mask;
    logic [fce_pkg::ROW_W-1:0]   cur_cand;
    logic [fce_pkg::CAND_AW-1:0] lvl_prev;
    logic [fce_pkg::CNT_W-1:0]   start_pos;
    logic [fce_pkg::CNT_W-1:0]   hit_pos;
    logic                        hit_none;

    // candidate set of the current level and next vertex in it
    always_comb begin
        act_mask  = fce_pkg::active_mask(i_count, VERTICES);
        lvl_prev  = fce_pkg::CAND_AW'(r_lvl - fce_pkg::LVL_W'(1));
        cur_cand  = (r_lvl == fce_pkg::LVL_ROOT) ? act_mask : r_cand[lvl_prev];
        start_pos = r_incl ? {1'b0, r_chosen[r_lvl]}
                           : {1'b0, r_chosen[r_lvl]} + fce_pkg::CNT_W'(1);
        hit_pos   = fce_pkg::first_set_from(cur_cand, start_pos);
        hit_none  = hit_pos[fce_pkg::CNT_W-1];
    end

    // fetch the chosen vertex's row whenever the path tries to go one level deeper
    assign o_rd_en   = (r_state == ST_FIND) && !hit_none && (r_lvl != fce_pkg::LVL_LAST);
    assign o_rd_addr = hit_pos[AW-1:0];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lvl       <= fce_pkg::LVL_ROOT;
            r_incl      <= 1'b0;
            r_done      <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_req.restart) begin
                        for (int k = 0; k < fce_pkg::CLIQUE_SIZE; k++) begin
                            r_chosen[k] <= '0;
                        end
                        r_lvl  <= fce_pkg::LVL_ROOT;
                        r_done <= 1'b0;
                        r_incl <= 1'b1;
                    end else if (i_req.fetch) begin
                        r_state <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    if (hit_none) begin
                        if (r_lvl == fce_pkg::LVL_ROOT) begin
                            // search exhausted
                            r_done      <= 1'b1;
                            r_incl      <= 1'b0;
                            r_res_valid <= 1'b1;
                            r_found     <= 1'b0;
                            r_vtx       <= '0;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_lvl  <= r_lvl - fce_pkg::LVL_W'(1);
                            r_incl <= 1'b0;
                        end
                    end else begin
                        r_chosen[r_lvl] <= hit_pos[fce_pkg::VTX_W-1:0];
                        if (r_lvl == fce_pkg::LVL_LAST) begin
                            // full clique
                            r_incl      <= 1'b0;
                            r_res_valid <= 1'b1;
                            r_found     <= 1'b1;
                            for (int k = 0; k < fce_pkg::CLIQUE_SIZE - 1; k++) begin
                                r_vtx[k] <= r_chosen[k];
                            end
                            r_vtx[fce_pkg::CLIQUE_SIZE-1] <= hit_pos[fce_pkg::VTX_W-1:0];
                            r_state     <= ST_IDLE;
                        end else begin
                            r_state <= ST_EXPAND;
                        end
                    end
                end
                ST_EXPAND: begin
                    // row data of the chosen vertex is on the read port now
                    r_cand[r_lvl[fce_pkg::CAND_AW-1:0]] <= cur_cand & i_rd_data;
                    if (r_lvl == fce_pkg::LVL_PAIR) begin
                        r_state <= ST_PRUNE;
                    end else begin
                        r_chosen[r_lvl + fce_pkg::LVL_W'(1)] <= r_chosen[r_lvl];
                        r_lvl   <= r_lvl + fce_pkg::LVL_W'(1);
                        r_incl  <= 1'b1;
                        r_state <= ST_FIND;
                    end
                end
                ST_PRUNE: begin
                    // pair with too few common neighbors: try the next partner
                    if (!fce_pkg::has_min_common(r_cand[fce_pkg::LVL_PAIR[fce_pkg::CAND_AW-1:0]]))
                    begin
                        r_incl <= 1'b0;
                    end else begin
                        r_chosen[r_lvl + fce_pkg::LVL_W'(1)] <= r_chosen[r_lvl];
                        r_lvl  <= r_lvl + fce_pkg::LVL_W'(1);
                        r_incl <= 1'b1;
                    end
                    r_state <= ST_FIND;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // status and result toward the top level
    always_comb begin
        o_rsp.busy      = (r_state != ST_IDLE);
        o_rsp.done      = r_done;
        o_rsp.res_valid = r_res_valid;
        o_rsp.found     = r_found;
        o_rsp.vtx       = r_vtx;
    end

    `FCE_ASSERT_NXT(a_rd_then_expand, i_rst_n, o_rd_en, r_state == ST_EXPAND, "row read not followed by expand")
    `FCE_ASSERT_IMP(a_lvl_range, i_rst_n, 1'b1, r_lvl <= fce_pkg::LVL_LAST, "search level out of range")
    `FCE_ASSERT_IMP(a_res_from_find, i_rst_n, r_res_valid, (r_state == ST_IDLE) && ($past(r_state) == ST_FIND), "result not issued from find step")
    `FCE_ASSERT_IMP(a_clique_sorted, i_rst_n, r_res_valid && r_found, (r_vtx[0] <= r_vtx[1]) && (r_vtx[1] <= r_vtx[2]) && (r_vtx[2] <= r_vtx[3]) && (r_vtx[3] <= r_vtx[4]), "clique vertices out of order")
    `FCE_ASSERT_IMP(a_miss_clean, i_rst_n, r_res_valid && !r_found, r_done && (r_lvl == fce_pkg::LVL_ROOT) && (r_vtx == '0), "not-found result with live search state")

endmodule

/* rtl/five_clique_enumerator_top.sv */
// Top level of the five-clique enumerator: stream ports, config, output register.
//
// Usage:
//   Input words arrive on s_axis_*. s_axis_tuser carries the mode: write an
//   adjacency row, restart the search, or fetch the next 5-clique. Every input
//   word yields exactly one output word on m_axis_*: m_axis_tuser is the found
//   flag, m_axis_tdata the five vertices, smallest first (zero when not found).
//   i_cfg_we / i_cfg_wdata set the vertex count; write it only while idle.
// Result path:
//   Row write, restart and any fetch after the search is exhausted: the result
//   is registered in the cycle after acceptance, one word per cycle while
//   m_axis_tready is high. Fetch: the search runs find steps (one priority
//   scan of a candidate set each), row reads (one per descent attempt,
//   through the single read port of the row memory) and pair prune checks;
//   the result passes through the search result register into the output
//   register. Input is held off while a fetch is in progress and in the
//   cycle its result is handed over.
// Reset:
//   Synchronous, active low. The search is marked exhausted, the vertex count
//   returns to 64, the output register empties. Row memory is not cleared.
// Backpressure:
//   A result waits in the output register until taken; a new word is accepted
//   in the cycle the waiting result leaves.
module five_clique_enumerator_top #(
    parameter int VERTICES = fce_pkg::VERTICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [5:0] row_index, [69:6] row_bits, [71:70] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] vertex_a .. [29:24] vertex_e, [31:30] zero
    output logic [0:0]  m_axis_tuser    // [0] found
);

    localparam int AW = $clog2(VERTICES);

    logic [fce_pkg::CNT_W-1:0] r_vcount;
    logic                      r_out_valid;
    logic                      r_out_found;
    fce_pkg::t_vtx [fce_pkg::CLIQUE_SIZE-1:0] r_out_vtx;

    fce_pkg::t_srch_req        srch_req;
    fce_pkg::t_srch_rsp        srch_rsp;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [fce_pkg::ROW_W-1:0] rd_data;

    logic                      in_acc;
    logic                      wr_en;
    logic [1:0]                in_mode;
    logic [fce_pkg::VTX_W-1:0] in_row_index;
    logic [fce_pkg::ROW_W-1:0] in_row_bits;

    // input word decode
    assign in_mode      = s_axis_tuser;
    assign in_row_index = s_axis_tdata[5:0];
    assign in_row_bits  = s_axis_tdata[69:6];

    // no new word during a search, its result hand-over, or an output stall
    assign s_axis_tready = !srch_rsp.busy && !srch_rsp.res_valid
                           && (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign srch_req.fetch   = in_acc && (in_mode == fce_pkg::MODE_FETCH) && !srch_rsp.done;
    assign srch_req.restart = in_acc && (in_mode == fce_pkg::MODE_RESTART);
    assign wr_en            = in_acc && (in_mode == fce_pkg::MODE_WRITE)
                              && ({1'b0, in_row_index} < fce_pkg::CNT_W'(VERTICES));

    // vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= fce_pkg::VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    // output register: immediate answers and search results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && !srch_req.fetch) begin
            r_out_valid <= 1'b1;
            r_out_found <= 1'b0;
            r_out_vtx   <= '0;
        end else if (srch_rsp.res_valid) begin
            r_out_valid <= 1'b1;
            r_out_found <= srch_rsp.found;
            r_out_vtx   <= srch_rsp.vtx;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {2'b00, r_out_vtx};

    fce_row_store #(
        .VERTICES (VERTICES)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (in_row_index[AW-1:0]),
        .i_wr_data (in_row_bits),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fce_search #(
        .VERTICES (VERTICES)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (srch_req),
        .i_count   (r_vcount),
        .o_rsp     (srch_rsp),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

endmodule
